FILE: sv/rms_pkg.sv
`default_nettype none

package rms_pkg;

  localparam int unsigned VALUE_IN_W = 32;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned STATUS_W   = 2;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic                         req_type;
    logic signed [VALUE_IN_W-1:0] value;
    logic                         last;
    logic [INDEX_W-1:0]           left_index;
    logic [INDEX_W-1:0]           right_index;
  } rms_in_t;

  typedef struct packed {
    logic signed [VALUE_IN_W-1:0] min_value;
    logic [STATUS_W-1:0]          status;
  } rms_out_t;

  // build sequencer to top level
  typedef struct packed {
    logic active;
    logic rd_en;
    logic wr_en;
  } rms_bld_ctl_t;

endpackage

`default_nettype wire

FILE: sv/rms_mem.sv
`default_nettype none

module rms_mem #(
  parameter int unsigned DEPTH = 11264,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 14
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rms_min.sv
`default_nettype none

module rms_min #(
  parameter int unsigned VW = 32
) (
  input  wire logic [VW-1:0] a,
  input  wire logic [VW-1:0] b,
  output logic      [VW-1:0] y
);

  // ties keep a
  assign y = ($signed(b) < $signed(a)) ? b : a;

endmodule

`default_nettype wire

FILE: sv/rms_build.sv
`default_nettype none

module rms_build import rms_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned LEVELS      = 11,
  parameter int unsigned CNT_W       = 11,
  parameter int unsigned AW          = 14
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [CNT_W-1:0] count,
  output rms_bld_ctl_t          ctl,
  output logic      [AW-1:0]    rd_addr_a,
  output logic      [AW-1:0]    rd_addr_b,
  output logic      [AW-1:0]    wr_addr
);

  localparam int unsigned SP_W  = CNT_W + 1;
  localparam int unsigned LVL_W = $clog2(LEVELS);

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_GAP
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [SP_W-1:0]   span_r, span_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     rbase_r, rbase_nxt;
  logic [AW-1:0]     wbase_r, wbase_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [SP_W-1:0]   half;

  assign half      = span_r >> 1;
  assign rd_addr_a = rbase_r + AW'(idx_r);
  assign rd_addr_b = rbase_r + AW'(idx_r) + AW'(half);
  assign wr_addr   = wr_addr_r;

  assign ctl.active = (state_r != B_IDLE);
  assign ctl.rd_en  = (state_r == B_RUN);
  assign ctl.wr_en  = wr_pend_r;

  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    span_nxt    = span_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    cnt_nxt     = cnt_r;
    rbase_nxt   = rbase_r;
    wbase_nxt   = wbase_r;
    wr_pend_nxt = (state_r == B_RUN);
    wr_addr_nxt = wbase_r + AW'(idx_r);
    case (state_r)
      B_IDLE: begin
        if (go && (count >= CNT_W'(2))) begin
          state_nxt = B_RUN;
          lvl_nxt   = LVL_W'(1);
          span_nxt  = SP_W'(2);
          idx_nxt   = '0;
          lim_nxt   = count - CNT_W'(2);
          cnt_nxt   = count;
          rbase_nxt = '0;
          wbase_nxt = AW'(MAX_ENTRIES);
        end
      end
      B_RUN: begin
        if (idx_r == lim_r) begin
          state_nxt = B_GAP;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      B_GAP: begin
        // last write of the level lands this cycle, next level may start
        if ((lvl_r == LVL_W'(LEVELS - 1)) || ((span_r << 1) > SP_W'(cnt_r))) begin
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_RUN;
          lvl_nxt   = lvl_r + LVL_W'(1);
          span_nxt  = span_r << 1;
          idx_nxt   = '0;
          lim_nxt   = CNT_W'(SP_W'(cnt_r) - (span_r << 1));
          rbase_nxt = wbase_r;
          wbase_nxt = wbase_r + AW'(MAX_ENTRIES);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
    lvl_r     <= lvl_nxt;
    span_r    <= span_nxt;
    idx_r     <= idx_nxt;
    lim_r     <= lim_nxt;
    cnt_r     <= cnt_nxt;
    rbase_r   <= rbase_nxt;
    wbase_r   <= wbase_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/range_min_sparse_table.sv
`default_nettype none

// range minimum engine on a sparse table held in one 2-read 1-write memory
//
// input: a transaction is taken at a clock edge with start high and busy low.
// a load (req_type 0) appends value to level 0 if not full; busy stays low.
// a load with last set starts the build: busy rises and stays high while the
// sequencer walks each level j from 1 up, one entry per cycle, with a gap
// state between levels, one memory write per cycle from the build sequencer.
// a query (req_type 1) reads both covering windows in one access of the two
// read ports; busy is high for one cycle, and no new request is taken then.
// output: out_strobe is high for exactly one cycle, registered from the
// S_QUERY state that follows the query, with out_data holding the minimum
// and status. the receiver cannot hold results off and none are needed to
// be held: one is in flight. loads never produce a result.
// reset clears state, strobe, loaded count and built flag; table memory is
// not cleared and needs no clearing pass, entries are read only once built.
module range_min_sparse_table import rms_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned LEVELS      = 11,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire rms_in_t in_data,
  output logic         out_strobe,
  output rms_out_t     out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DEPTH = LEVELS * MAX_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EXT_W = (VALUE_WIDTH > VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;
  localparam int unsigned QW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int unsigned LEN_W = INDEX_W + 1;
  localparam int unsigned JW    = $clog2(LEN_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUERY,
    S_LAUNCH,
    S_BUILD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ready_r, ready_nxt;
  logic [STATUS_W-1:0] q_status_r, q_status_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  rms_out_t            out_data_r, out_data_nxt;

  // memory ports
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_a, mem_rd_b;
  logic [VALUE_WIDTH-1:0] mem_q_a, mem_q_b;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;

  // build sequencer
  rms_bld_ctl_t  bld_ctl;
  logic [AW-1:0] bld_rd_a, bld_rd_b, bld_wr_addr;

  // accept-cycle decode
  logic                   accept;
  logic [CNT_W-1:0]       cnt_eff;
  logic                   load_wr;
  logic [VALUE_WIDTH-1:0] load_val;
  logic [EXT_W-1:0]       val_zx;
  logic                   q_bad;
  logic                   q_rd;
  logic [LEN_W-1:0]       q_len;
  logic [JW-1:0]          q_lvl;
  logic [AW-1:0]          q_base;
  logic [AW-1:0]          q_addr_a, q_addr_b;

  // smaller of the two read words, shared by build and query
  logic [VALUE_WIDTH-1:0] min_w;
  logic signed [EXT_W-1:0] min_sx;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign val_zx   = EXT_W'($unsigned(in_data.value));
  assign load_val = val_zx[VALUE_WIDTH-1:0];
  assign min_sx   = EXT_W'($signed(min_w));

  // a load after a build restarts the array
  assign cnt_eff = ready_r ? '0 : count_r;
  assign load_wr = accept && (in_data.req_type == REQ_LOAD)
                   && (cnt_eff < CNT_W'(MAX_ENTRIES));

  // query window selection
  always_comb begin
    q_len = LEN_W'(in_data.right_index) - LEN_W'(in_data.left_index) + LEN_W'(1);
    q_lvl = '0;
    for (int k = 1; k < LEN_W; k++) begin
      if (q_len[k]) begin
        q_lvl = JW'(k);
      end
    end
    if (32'(q_lvl) > LEVELS - 1) begin
      q_lvl = JW'(LEVELS - 1);
    end
  end

  assign q_bad    = (in_data.left_index > in_data.right_index)
                    || (QW'(in_data.right_index) >= QW'(count_r));
  assign q_rd     = accept && (in_data.req_type == REQ_QUERY) && ready_r && !q_bad;
  assign q_base   = AW'(q_lvl) * AW'(MAX_ENTRIES);
  assign q_addr_a = q_base + AW'(in_data.left_index);
  assign q_addr_b = q_base + AW'(in_data.right_index) + AW'(1) - (AW'(1) << q_lvl);

  // port sharing: the sequencer owns the memory while it runs
  assign mem_rd_en   = bld_ctl.rd_en || q_rd;
  assign mem_rd_a    = bld_ctl.rd_en ? bld_rd_a : q_addr_a;
  assign mem_rd_b    = bld_ctl.rd_en ? bld_rd_b : q_addr_b;
  assign mem_wr_en   = bld_ctl.wr_en || load_wr;
  assign mem_wr_addr = bld_ctl.wr_en ? bld_wr_addr : AW'(cnt_eff);
  assign mem_wr_data = bld_ctl.wr_en ? min_w : load_val;

  rms_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (mem_rd_en),
    .rd_addr_a (mem_rd_a),
    .rd_addr_b (mem_rd_b),
    .rd_data_a (mem_q_a),
    .rd_data_b (mem_q_b),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data)
  );

  rms_min #(
    .VW (VALUE_WIDTH)
  ) u_min (
    .a (mem_q_a),
    .b (mem_q_b),
    .y (min_w)
  );

  rms_build #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .LEVELS      (LEVELS),
    .CNT_W       (CNT_W),
    .AW          (AW)
  ) u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (state_r == S_LAUNCH),
    .count     (count_r),
    .ctl       (bld_ctl),
    .rd_addr_a (bld_rd_a),
    .rd_addr_b (bld_rd_b),
    .wr_addr   (bld_wr_addr)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ready_nxt      = ready_r;
    q_status_nxt   = q_status_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_LOAD) begin
            ready_nxt = 1'b0;
            count_nxt = load_wr ? (cnt_eff + CNT_W'(1)) : cnt_eff;
            if (in_data.last) begin
              state_nxt = S_LAUNCH;
            end
          end else begin
            state_nxt = S_QUERY;
            if (!ready_r) begin
              q_status_nxt = ST_NOT_BUILT;
            end else if (q_bad) begin
              q_status_nxt = ST_BAD_RANGE;
            end else begin
              q_status_nxt = ST_OK;
            end
          end
        end
      end
      S_QUERY: begin
        // read data is back, present the result for one cycle
        state_nxt              = S_IDLE;
        out_strobe_nxt         = 1'b1;
        out_data_nxt.status    = q_status_r;
        out_data_nxt.min_value = (q_status_r == ST_OK) ? $signed(min_sx[VALUE_IN_W-1:0])
                                                       : '0;
      end
      S_LAUNCH: begin
        state_nxt = S_BUILD;
      end
      S_BUILD: begin
        if (!bld_ctl.active) begin
          state_nxt = S_IDLE;
          ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ready_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ready_r      <= ready_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    q_status_r <= q_status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

FILE: dv/range_min_sparse_table_test.sv
module range_min_sparse_table_test;
  import rms_pkg::*;

  // depth of the level 0 array in the block as configured
  localparam int unsigned MAX_ENTRIES = 1024;
  // generous ceiling on the cycle count of the whole run
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // settle time before the final check for results still owed
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic signed [VALUE_IN_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_IN_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  rms_in_t  in_data = '0;
  logic     busy;
  logic     out_strobe;
  rms_out_t out_data;

  range_min_sparse_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // requests waiting to be driven, filled by the stimulus block at falling edges
  rms_in_t request_queue[$];
  // minima and status words still owed by the block, oldest first
  rms_out_t expected_minima[$];
  // percentage of cycles in which the sender holds back a ready request
  int unsigned send_idle_pct = 33;
  int unsigned items_queued = 0;

  // shadow of the block state: level 0 values, loaded count and built flag.
  // the minimum over a range is the same whichever windows cover it, so a
  // straight scan of level 0 stands in for the two-window table lookup
  logic signed [VALUE_IN_W-1:0] stored_vals [MAX_ENTRIES];
  int unsigned stored_count = 0;
  bit          table_built = 1'b0;

  // run statistics
  int unsigned n_loads = 0, n_dropped = 0, n_builds = 0, widest_set = 0;
  int unsigned n_ok = 0, n_bad_range = 0, n_unbuilt = 0;
  int unsigned results_seen = 0, fail_events = 0;

  // --------------------------------------------------------------------------
  // predictor: update the shadow state for one accepted transaction and, for
  // a query, queue the result it must produce
  // --------------------------------------------------------------------------
  function automatic void predict_range_min(rms_in_t req);
    rms_out_t res;
    logic signed [VALUE_IN_W-1:0] low;
    if (req.req_type == REQ_LOAD) begin
      n_loads++;
      // a load after a build starts a fresh array
      if (table_built) begin
        table_built = 1'b0;
        stored_count = 0;
      end
      // a full array drops the value, but last still builds
      if (stored_count < MAX_ENTRIES) begin
        stored_vals[stored_count] = req.value;
        stored_count++;
      end else begin
        n_dropped++;
      end
      if (req.last) begin
        table_built = 1'b1;
        n_builds++;
        if (stored_count > widest_set) widest_set = stored_count;
      end
    end else begin
      res.min_value = '0;
      if (!table_built) begin
        res.status = ST_NOT_BUILT;
        n_unbuilt++;
      end else if (req.left_index > req.right_index || req.right_index >= stored_count) begin
        res.status = ST_BAD_RANGE;
        n_bad_range++;
      end else begin
        low = stored_vals[req.left_index];
        for (int unsigned i = req.left_index + 1; i <= req.right_index; i++) begin
          if (stored_vals[i] < low) low = stored_vals[i];
        end
        res.status = ST_OK;
        res.min_value = low;
        n_ok++;
      end
      expected_minima.push_back(res);
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: a transaction is taken at an edge with start high and busy low.
  // once raised, start holds its request until taken; idling is only decided
  // while start is low or right after a hand-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    bit took;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) predict_range_min(request_queue.pop_front());
      if (!start || took) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start   <= 1'b1;
          in_data <= request_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobe is one result transaction, compared field by field
  // against the oldest outstanding expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    rms_out_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_minima.size() == 0) begin
        fail_events++;
        if (fail_events <= 10)
          $display("unexpected result: min_value %0d status %0d",
                   out_data.min_value, out_data.status);
      end else begin
        want = expected_minima.pop_front();
        if (out_data.status !== want.status || out_data.min_value !== want.min_value) begin
          fail_events++;
          if (fail_events <= 10)
            $display("result mismatch: expected min_value %0d status %0d, got %0d status %0d",
                     want.min_value, want.status, out_data.min_value, out_data.status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers, all called from the falling edge side
  // --------------------------------------------------------------------------

  // index fields are random on loads since the block must ignore them
  task automatic push_load(logic signed [VALUE_IN_W-1:0] v, bit fin);
    rms_in_t req;
    req.req_type    = REQ_LOAD;
    req.value       = v;
    req.last        = fin;
    req.left_index  = $urandom_range(1023);
    req.right_index = $urandom_range(1023);
    request_queue.push_back(req);
    items_queued++;
  endtask

  // value and last are random on queries for the same reason
  task automatic push_query(int unsigned l, int unsigned r);
    rms_in_t req;
    req.req_type    = REQ_QUERY;
    req.value       = $urandom;
    req.last        = $urandom_range(1);
    req.left_index  = l;
    req.right_index = r;
    request_queue.push_back(req);
    items_queued++;
  endtask

  // extremes, a narrow band that makes ties common, or anything at all
  function automatic logic signed [VALUE_IN_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return $urandom_range(1) ? -1 : 0;
      3, 4:    return int'($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // one query against an array of n values: mostly in range, with window
  // lengths often on or next to a power of two, the rest malformed
  task automatic queue_query(int unsigned n);
    int unsigned span, l, r, p;
    case ($urandom_range(19))
      0, 1: begin
        // left past right
        l = $urandom_range(1023, 1);
        r = $urandom_range(l - 1);
      end
      2, 3, 4: begin
        // right beyond the loaded count, or left past right for a full array
        if (n < MAX_ENTRIES) begin
          r = $urandom_range(1023, n);
          l = $urandom_range(1023);
        end else begin
          l = 1023;
          r = $urandom_range(1022);
        end
      end
      5: begin
        l = $urandom_range(1023);
        r = $urandom_range(1023);
      end
      default: begin
        if ($urandom_range(1)) begin
          span = $urandom_range(n, 1);
        end else begin
          p = 0;
          while ((2 << p) <= n) p++;
          span = (1 << $urandom_range(p)) + $urandom_range(2) - 1;
          if (span == 0) span = 1;
          if (span > n) span = n;
        end
        l = $urandom_range(n - span);
        r = l + span - 1;
      end
    endcase
    push_query(l, r);
  endtask

  // a well formed set: n loads closed by last, then a burst of queries.
  // a broken set asks before the build and then finishes the loads
  task automatic queue_session(int unsigned n, bit broken);
    int unsigned split, k;
    split = (broken && n >= 2) ? $urandom_range(n - 1, 1) : 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (split != 0 && i == split) begin
        k = $urandom_range(3, 1);
        repeat (k) queue_query(n);
      end
      push_load(pick_value(), i == n - 1);
    end
    k = $urandom_range(12, 1);
    repeat (k) queue_query(n);
  endtask

  // mostly small sets, a few medium ones, plus stray queries and loads
  task automatic queue_random_step();
    int unsigned sel, n;
    sel = $urandom_range(99);
    if (sel < 85) begin
      case ($urandom_range(9))
        0:          n = $urandom_range(300, 65);
        1, 2, 3:    n = $urandom_range(64, 17);
        default:    n = $urandom_range(16, 1);
      endcase
      queue_session(n, $urandom_range(9) == 0);
    end else if (sel < 95) begin
      push_query($urandom_range(1023), $urandom_range(1023));
    end else begin
      // stray load: unbuilds any table, so what follows sees no table
      push_load(pick_value(), 1'b0);
    end
    // now and then the sender holds off until every result is back
    if ($urandom_range(7) == 0) wait_for_drain();
  endtask

  task automatic wait_for_drain();
    do @(negedge clk); while (request_queue.size() != 0 || expected_minima.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned stop_at;

    // directed: query before anything is built
    push_query(0, 0);
    // extremes of the value field, then windows of length 1, 2, 3 and 5
    push_load(VAL_MAX, 1'b0);
    push_load(VAL_MIN, 1'b0);
    push_load(-1, 1'b0);
    push_load(0, 1'b0);
    push_load(1, 1'b1);
    push_query(0, 0);
    push_query(0, 4);
    push_query(2, 4);
    push_query(3, 4);
    // empty range, right at the count, and the index extremes out of range
    push_query(4, 3);
    push_query(0, 5);
    push_query(1023, 1023);
    push_query(0, 1023);
    // load after a build restarts with a single entry
    push_load(42, 1'b1);
    push_query(0, 0);
    push_query(1, 1);
    // load without last leaves the table unbuilt, then complete it
    push_load(VAL_MIN, 1'b0);
    push_query(0, 0);
    push_load(VAL_MAX, 1'b1);
    push_query(0, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: the sender idles a third of the time
    wait_for_drain();
    stop_at = items_queued + 20;
    while (items_queued < stop_at) queue_random_step();

    // phase two: the sender idles most of the time
    wait_for_drain();
    send_idle_pct = 63;
    stop_at = items_queued + 20;
    while (items_queued < stop_at) queue_random_step();

    // phase three: back to back with one full array; the extra loads past
    // the end must be dropped, and the last of them still builds
    wait_for_drain();
    send_idle_pct = 0;
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) push_load(pick_value(), 1'b0);
    push_load(VAL_MIN, 1'b0);
    push_load(VAL_MIN, 1'b1);
    push_query(0, 1023);
    push_query(1023, 1023);
    push_query(0, 0);
    push_query(512, 1023);
    push_query(1, 1023);
    repeat (25) queue_query(MAX_ENTRIES);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_minima.size() != 0) begin
      $display("%0d results never arrived", expected_minima.size());
      fail_events += expected_minima.size();
    end

    $display("exercised %0d loads (%0d dropped at a full array), %0d builds, widest set %0d",
             n_loads, n_dropped, n_builds, widest_set);
    $display("queries: %0d in range, %0d bad range, %0d before a build; %0d results checked",
             n_ok, n_bad_range, n_unbuilt, results_seen);
    if (fail_events == 0) begin
      $display("[range_min_sparse_table] OK");
    end else begin
      $display("[range_min_sparse_table] ERROR");
    end
    $finish;
  end

  // watchdog on the cycle counter
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles", cycle_count);
    $display("[range_min_sparse_table] ERROR");
    $finish;
  end

endmodule
